@@ design/rpd_pkg.sv @@
// Shared types, constants and helper functions of the radial potential derivative block.
package rpd_pkg;

	localparam int DATA_W             = 48;
	localparam int POINT_W            = 16;
	localparam int IDX_W              = 10;
	localparam int WIN_DEPTH          = 8;
	localparam int SLOT_W             = $clog2(WIN_DEPTH);
	localparam int TAPS               = 7;
	localparam int KAPPA_W            = 6;
	localparam int LIGHT_W            = 32;
	localparam int GRID_W             = 24;
	localparam int CFG_W              = 32;
	localparam int REG_IDX_W          = 2;
	localparam int MUL_W              = 64;
	localparam int PROD_W             = 2 * MUL_W;
	localparam int NUM_W              = 112;
	localparam int DEN_W              = 80;
	localparam int MAX_JOBS           = 6;
	localparam int QUEUE_DEPTH        = 8;
	localparam int DEFAULT_MAX_POINTS = 1024;

	localparam logic signed [KAPPA_W-1:0] KAPPA_RESET = -6'sd1;
	localparam logic [LIGHT_W-1:0]        LIGHT_RESET = 32'd8980791;
	localparam logic [GRID_W-1:0]         GRID_RESET  = 24'd838861;

	// Register indexes of the configuration port
	typedef enum logic [REG_IDX_W-1:0] {
		REG_KAPPA = 2'd0,
		REG_LIGHT = 2'd1,
		REG_GRID  = 2'd2
	} reg_idx_t;

	// Difference formula used for one grid point
	typedef enum logic [1:0] {
		ST_ONE_SIDED,
		ST_CENTRAL,
		ST_NEXT_LAST,
		ST_LAST
	} stencil_t;

	// One result request handed from the front to the back
	typedef struct packed {
		logic [POINT_W-1:0] point;
		stencil_t           kind;
		logic               fin;
		logic               short_run;
	} job_t;

	typedef struct packed {
		logic signed [KAPPA_W-1:0] kappa;
		logic [LIGHT_W-1:0]        light;
		logic [GRID_W-1:0]         grid;
	} cfg_t;

	// Window write from the front
	typedef struct packed {
		logic                     we;
		logic [SLOT_W-1:0]        slot;
		logic signed [DATA_W-1:0] wre;
		logic signed [DATA_W-1:0] wim;
		logic [DATA_W-1:0]        rad;
	} win_wr_t;

	// Stencil coefficient of one tap; taps start at the stencil base
	function automatic logic signed [9:0] stencil_coef(stencil_t kind, logic [2:0] tap);
		logic signed [9:0] c;
		c = '0;
		case (kind)
			ST_ONE_SIDED: begin
				case (tap)
					3'd0: c = -10'sd147;
					3'd1: c = 10'sd360;
					3'd2: c = -10'sd450;
					3'd3: c = 10'sd400;
					3'd4: c = -10'sd225;
					3'd5: c = 10'sd72;
					3'd6: c = -10'sd10;
					default: c = '0;
				endcase
			end
			ST_CENTRAL: begin
				case (tap)
					3'd0: c = 10'sd1;
					3'd1: c = -10'sd8;
					3'd3: c = 10'sd8;
					3'd4: c = -10'sd1;
					default: c = '0;
				endcase
			end
			ST_NEXT_LAST: begin
				case (tap)
					3'd0: c = -10'sd1;
					3'd2: c = 10'sd1;
					default: c = '0;
				endcase
			end
			default: begin
				case (tap)
					3'd0: c = 10'sd1;
					3'd1: c = -10'sd4;
					3'd2: c = 10'sd3;
					default: c = '0;
				endcase
			end
		endcase
		return c;
	endfunction

	// Slot offset of the first tap relative to the point
	function automatic logic [SLOT_W-1:0] stencil_base(stencil_t kind);
		case (kind)
			ST_ONE_SIDED: return SLOT_W'(0);
			ST_NEXT_LAST: return SLOT_W'(WIN_DEPTH - 1);
			default:      return SLOT_W'(WIN_DEPTH - 2);
		endcase
	endfunction

	// Common divisor of the stencil sum
	function automatic logic [5:0] stencil_div(stencil_t kind);
		case (kind)
			ST_ONE_SIDED: return 6'd60;
			ST_CENTRAL:   return 6'd12;
			default:      return 6'd2;
		endcase
	endfunction

	// Signed 48-bit result from sign and magnitude, saturated
	function automatic logic signed [DATA_W-1:0] sat48(logic neg, logic big,
			logic [DATA_W-1:0] mag);
		logic [DATA_W-1:0] r;
		if (big || mag[DATA_W-1])
			r = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		else
			r = neg ? (~mag + 1'b1) : mag;
		return r;
	endfunction

endpackage

@@ design/rpd_if.sv @@
// Sample and result channels of the radial potential derivative block.
interface rpd_sample_if import rpd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] pot_re;
	logic signed [DATA_W-1:0] pot_im;
	logic [DATA_W-1:0]        radius;
	logic                     last_point;

	modport source(output valid, pot_re, pot_im, radius, last_point, input ready);
	modport sink(input valid, pot_re, pot_im, radius, last_point, output ready);
endinterface

interface rpd_result_if import rpd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] deriv_re;
	logic signed [DATA_W-1:0] deriv_im;
	logic [IDX_W-1:0]         point_index;
	logic                     final_result;
	logic                     too_short;

	modport source(output valid, deriv_re, deriv_im, point_index, final_result, too_short,
		input ready);
	modport sink(input valid, deriv_re, deriv_im, point_index, final_result, too_short,
		output ready);
endinterface

@@ design/rpd_mul.sv @@
// Iterative 64x64 multiplier built from four registered 32x32 partial products.
module rpd_mul import rpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	localparam int HALF_W = MUL_W / 2;
	localparam logic [2:0] STEPS = 3'd4;

	logic [MUL_W-1:0]    a_q, b_q;
	logic [2:0]          idx_q;
	logic                busy_q, done_q;
	logic [MUL_W-1:0]    pp_s1;
	logic [6:0]          sh_s1;
	logic [PROD_W-1:0]   acc_q;
	logic [HALF_W-1:0]   asel, bsel;
	logic [1:0]          hcnt;

	// Partial product operand selection
	always_comb begin
		asel = idx_q[0] ? a_q[MUL_W-1:HALF_W] : a_q[HALF_W-1:0];
		bsel = idx_q[1] ? b_q[MUL_W-1:HALF_W] : b_q[HALF_W-1:0];
		hcnt = {1'b0, idx_q[0]} + {1'b0, idx_q[1]};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == STEPS) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands, partial products and accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (idx_q != STEPS) begin
				pp_s1 <= asel * bsel;
				sh_s1 <= {hcnt, 5'd0};
			end
			if (idx_q != 3'd0)
				acc_q <= acc_q + ({{MUL_W{1'b0}}, pp_s1} << sh_s1);
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ design/rpd_div.sv @@
// Radix-2 restoring divider with round-to-nearest and 48-bit overflow flag.
module rpd_div import rpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              done,
	output logic              big,
	output logic [DATA_W-1:0] quo
);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_ROUND} div_state_t;

	div_state_t        state_q;
	logic              done_q, big_q;
	logic [DEN_W-1:0]  rem_q, den_q;
	logic [DATA_W-1:0] low_q, q_q;
	logic [5:0]        cnt_q;
	logic [DEN_W:0]    trial, trial_sub, rnd;
	logic              fits;

	// One quotient bit per cycle
	always_comb begin
		trial     = {rem_q, low_q[DATA_W-1]};
		trial_sub = trial - {1'b0, den_q};
		rnd       = {rem_q, 1'b0};
		fits      = {{(DEN_W-(NUM_W-DATA_W)){1'b0}}, num[NUM_W-1:DATA_W]} < den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			big_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						if (num == '0) begin
							big_q  <= 1'b0;
							done_q <= 1'b1;
						end else if (!fits) begin
							big_q  <= 1'b1;
							done_q <= 1'b1;
						end else begin
							big_q   <= 1'b0;
							state_q <= D_RUN;
						end
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DATA_W - 1))
						state_q <= D_ROUND;
				end
				D_ROUND: begin
					if (rnd >= {1'b0, den_q} && q_q == '1)
						big_q <= 1'b1;
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					rem_q <= DEN_W'(num[NUM_W-1:DATA_W]);
					low_q <= num[DATA_W-1:0];
					den_q <= den;
					q_q   <= '0;
				end
			end
			D_RUN: begin
				low_q <= {low_q[DATA_W-2:0], 1'b0};
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial_sub[DEN_W-1:0];
					q_q   <= {q_q[DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[DEN_W-1:0];
					q_q   <= {q_q[DATA_W-2:0], 1'b0};
				end
			end
			D_ROUND: begin
				if (rnd >= {1'b0, den_q})
					q_q <= q_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign big  = big_q;
	assign quo  = q_q;

endmodule

@@ design/rpd_front.sv @@
// Front end: accepts samples, forms weighted samples and issues result requests.
module rpd_front import rpd_pkg::*; #(
	parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
	input  logic                clk,
	input  logic                arst_n,
	rpd_sample_if.sink          samples,
	input  logic                back_idle,
	input  logic                queue_full,
	output win_wr_t             win_wr,
	output logic                push,
	output job_t                push_job
);

	localparam int PW = $clog2(MAX_POINTS);

	typedef enum logic [2:0] {
		F_IDLE, F_MUL1_GO, F_MUL1_WAIT, F_MUL2_GO, F_MUL2_WAIT, F_COMMIT, F_PUSH
	} front_state_t;

	front_state_t             state_q;
	logic                     comp_q;
	logic [PW-1:0]            k_q;
	logic [2:0]               njobs_q, jn_q;
	job_t                     jobs_q [MAX_JOBS];
	logic signed [DATA_W-1:0] re_q, im_q, wre_q, wim_q;
	logic [DATA_W-1:0]        rad_q;
	logic                     last_q;
	logic [56:0]              t_q;

	logic                     mul_start, mul_done;
	logic [MUL_W-1:0]         mul_a, mul_b;
	logic [PROD_W-1:0]        mul_prod;
	logic [PROD_W-1:0]        rounded;
	logic                     neg;
	logic [DATA_W-1:0]        vmag;
	logic signed [DATA_W-1:0] wnew;
	logic                     last_eff;
	job_t                     jobs_d [MAX_JOBS];
	logic [2:0]               njobs_d;
	logic                     commit;

	rpd_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	// Weighting: |v|*R then *R, each rounded by 2^40
	always_comb begin
		neg       = comp_q ? im_q[DATA_W-1] : re_q[DATA_W-1];
		vmag      = comp_q ? (im_q[DATA_W-1] ? -im_q : im_q)
		                   : (re_q[DATA_W-1] ? -re_q : re_q);
		mul_start = (state_q == F_MUL1_GO) || (state_q == F_MUL2_GO);
		mul_a     = (state_q == F_MUL2_GO) ? MUL_W'(t_q) : MUL_W'(vmag);
		mul_b     = MUL_W'(rad_q);
		rounded   = (mul_prod + (PROD_W'(1) << 39)) >> 40;
		wnew      = sat48(neg, |rounded[PROD_W-1:DATA_W], rounded[DATA_W-1:0]);
	end

	// Result requests caused by the current item
	always_comb begin
		last_eff = last_q || (k_q >= PW'(MAX_POINTS - 1));
		njobs_d  = '0;
		for (int i = 0; i < MAX_JOBS; i++)
			jobs_d[i] = '0;
		if (last_eff && k_q < PW'(7)) begin
			jobs_d[0] = '{point: '0, kind: ST_LAST, fin: 1'b1, short_run: 1'b1};
			njobs_d   = 3'd1;
		end else begin
			if (k_q == PW'(6)) begin
				jobs_d[0] = '{point: POINT_W'(0), kind: ST_ONE_SIDED, fin: 1'b0, short_run: 1'b0};
				jobs_d[1] = '{point: POINT_W'(2), kind: ST_CENTRAL, fin: 1'b0, short_run: 1'b0};
				jobs_d[2] = '{point: POINT_W'(3), kind: ST_CENTRAL, fin: 1'b0, short_run: 1'b0};
				jobs_d[3] = '{point: POINT_W'(4), kind: ST_CENTRAL, fin: 1'b0, short_run: 1'b0};
				njobs_d   = 3'd4;
			end else if (k_q == PW'(7)) begin
				jobs_d[0] = '{point: POINT_W'(1), kind: ST_ONE_SIDED, fin: 1'b0, short_run: 1'b0};
				jobs_d[1] = '{point: POINT_W'(5), kind: ST_CENTRAL, fin: 1'b0, short_run: 1'b0};
				njobs_d   = 3'd2;
			end else if (k_q >= PW'(8)) begin
				jobs_d[0] = '{point: POINT_W'(k_q - PW'(2)), kind: ST_CENTRAL, fin: 1'b0,
					short_run: 1'b0};
				njobs_d   = 3'd1;
			end
			if (last_eff) begin
				jobs_d[njobs_d] = '{point: POINT_W'(k_q - PW'(1)), kind: ST_NEXT_LAST,
					fin: 1'b0, short_run: 1'b0};
				jobs_d[njobs_d + 3'd1] = '{point: POINT_W'(k_q), kind: ST_LAST, fin: 1'b1,
					short_run: 1'b0};
				njobs_d = njobs_d + 3'd2;
			end
		end
	end

	// The window is written only while the back holds no pending work
	always_comb begin
		commit        = (state_q == F_COMMIT) && back_idle;
		win_wr.we     = commit;
		win_wr.slot   = k_q[SLOT_W-1:0];
		win_wr.wre    = wre_q;
		win_wr.wim    = wim_q;
		win_wr.rad    = rad_q;
		push          = (state_q == F_PUSH) && !queue_full;
		push_job      = jobs_q[jn_q];
		samples.ready = (state_q == F_IDLE);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			comp_q  <= 1'b0;
			k_q     <= '0;
			njobs_q <= '0;
			jn_q    <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (samples.valid) begin
						comp_q  <= 1'b0;
						state_q <= F_MUL1_GO;
					end
				end
				F_MUL1_GO: state_q <= F_MUL1_WAIT;
				F_MUL1_WAIT: if (mul_done) state_q <= F_MUL2_GO;
				F_MUL2_GO: state_q <= F_MUL2_WAIT;
				F_MUL2_WAIT: begin
					if (mul_done) begin
						comp_q  <= 1'b1;
						state_q <= comp_q ? F_COMMIT : F_MUL1_GO;
					end
				end
				F_COMMIT: begin
					if (back_idle) begin
						k_q     <= last_eff ? '0 : k_q + PW'(1);
						njobs_q <= njobs_d;
						jn_q    <= '0;
						state_q <= (njobs_d == '0) ? F_IDLE : F_PUSH;
					end
				end
				F_PUSH: begin
					if (!queue_full) begin
						jn_q <= jn_q + 3'd1;
						if (jn_q + 3'd1 == njobs_q)
							state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Sample and weight registers
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && samples.valid) begin
			re_q   <= samples.pot_re;
			im_q   <= samples.pot_im;
			rad_q  <= samples.radius;
			last_q <= samples.last_point;
		end
		if (state_q == F_MUL1_WAIT && mul_done)
			t_q <= rounded[56:0];
		if (state_q == F_MUL2_WAIT && mul_done) begin
			if (comp_q)
				wim_q <= wnew;
			else
				wre_q <= wnew;
		end
		if (commit) begin
			for (int i = 0; i < MAX_JOBS; i++)
				jobs_q[i] <= jobs_d[i];
		end
	end

endmodule

@@ design/rpd_queue.sv @@
// Request queue between front and back.
module rpd_queue import rpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head  = mem_q[rd_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

endmodule

@@ design/rpd_back.sv @@
// Back end: evaluates stencils, divides and scales, and drives the result register.
module rpd_back import rpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  win_wr_t     win_wr,
	input  job_t        head,
	input  logic        queue_empty,
	output logic        pop,
	output logic        back_idle,
	rpd_result_if.source derivs
);

	typedef enum logic [3:0] {
		B_IDLE, B_RAD, B_RC_GO, B_RC_WAIT, B_TAPS, B_D1_GO, B_D1_WAIT, B_F,
		B_D2_GO, B_D2_WAIT, B_OUT
	} back_state_t;

	back_state_t              state_q;
	job_t                     job_q;
	logic                     comp_q;
	logic [3:0]               tap_q;
	logic signed [DATA_W-1:0] wre_q [WIN_DEPTH];
	logic signed [DATA_W-1:0] wim_q [WIN_DEPTH];
	logic [DATA_W-1:0]        rad_q [WIN_DEPTH];
	logic [DATA_W-1:0]        rad_s1;
	logic signed [DATA_W-1:0] rd_s1, wp_q, d_q, res_re_q, res_im_q;
	logic signed [9:0]        coef_s1;
	logic signed [63:0]       acc_q;
	logic [DEN_W-1:0]         rc_q;
	logic signed [56:0]       f_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_re_q, out_im_q;
	logic [IDX_W-1:0]         out_idx_q;
	logic                     out_fin_q, out_short_q;

	logic [SLOT_W-1:0]        rd_slot;
	logic signed [DATA_W-1:0] rd_data;
	logic signed [57:0]       tap_prod;
	logic [29:0]              grid_den;
	logic [63:0]              acc_mag;
	logic [56:0]              f_mag;
	logic signed [49:0]       diff;
	logic signed [6:0]        kp1;
	logic                     mul_start, mul_done;
	logic [PROD_W-1:0]        mul_prod;
	logic                     div_start, div_done, div_big;
	logic [NUM_W-1:0]         div_num;
	logic [DEN_W-1:0]         div_den;
	logic [DATA_W-1:0]        div_quo;
	logic signed [DATA_W-1:0] res;
	logic                     out_free;

	rpd_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (MUL_W'(rad_s1)),
		.b     (MUL_W'(cfg.light)),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	rpd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.big   (div_big),
		.quo   (div_quo)
	);

	// Window read slot: stencil taps, then the point itself
	always_comb begin
		if (tap_q < 4'(TAPS))
			rd_slot = job_q.point[SLOT_W-1:0] + stencil_base(job_q.kind) + tap_q[SLOT_W-1:0];
		else
			rd_slot = job_q.point[SLOT_W-1:0];
		rd_data  = comp_q ? wim_q[rd_slot] : wre_q[rd_slot];
		tap_prod = coef_s1 * rd_s1;
	end

	// Division operands and sign handling
	always_comb begin
		acc_mag   = acc_q[63] ? -acc_q : acc_q;
		kp1       = {cfg.kappa[KAPPA_W-1], cfg.kappa} + 7'sd1;
		diff      = {{2{d_q[DATA_W-1]}}, d_q} - {wp_q[DATA_W-1], wp_q, 1'b0};
		f_mag     = f_q[56] ? -f_q : f_q;
		grid_den  = stencil_div(job_q.kind) * cfg.grid;
		mul_start = (state_q == B_RC_GO);
		div_start = (state_q == B_D1_GO) || (state_q == B_D2_GO);
		if (state_q == B_D2_GO) begin
			div_num = {f_mag[55:0], 56'd0};
			div_den = rc_q;
		end else begin
			div_num = NUM_W'({acc_mag, 24'd0});
			div_den = DEN_W'(grid_den);
		end
		res       = sat48(f_q[56], div_big, div_quo);
	end

	always_comb begin
		out_free  = !out_valid_q || derivs.ready;
		pop       = (state_q == B_IDLE) && !queue_empty;
		back_idle = (state_q == B_IDLE) && queue_empty;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			comp_q      <= 1'b0;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == B_OUT && out_free) || (out_valid_q && !derivs.ready);
			unique case (state_q)
				B_IDLE: begin
					if (!queue_empty)
						state_q <= head.short_run ? B_OUT : B_RAD;
				end
				B_RAD: state_q <= B_RC_GO;
				B_RC_GO: state_q <= B_RC_WAIT;
				B_RC_WAIT: begin
					if (mul_done) begin
						comp_q  <= 1'b0;
						tap_q   <= '0;
						state_q <= B_TAPS;
					end
				end
				B_TAPS: begin
					tap_q <= tap_q + 4'd1;
					if (tap_q == 4'(TAPS + 1))
						state_q <= B_D1_GO;
				end
				B_D1_GO: state_q <= B_D1_WAIT;
				B_D1_WAIT: if (div_done) state_q <= B_F;
				B_F: state_q <= B_D2_GO;
				B_D2_GO: state_q <= B_D2_WAIT;
				B_D2_WAIT: begin
					if (div_done) begin
						comp_q  <= 1'b1;
						tap_q   <= '0;
						state_q <= comp_q ? B_OUT : B_TAPS;
					end
				end
				B_OUT: begin
					if (out_free)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Window storage
	always_ff @(posedge clk) begin
		if (win_wr.we) begin
			wre_q[win_wr.slot] <= win_wr.wre;
			wim_q[win_wr.slot] <= win_wr.wim;
			rad_q[win_wr.slot] <= win_wr.rad;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head;
		if (state_q == B_RAD)
			rad_s1 <= rad_q[job_q.point[SLOT_W-1:0]];
		if (state_q == B_RC_WAIT && mul_done)
			rc_q <= mul_prod[DEN_W-1:0];
		if (state_q == B_TAPS) begin
			rd_s1   <= rd_data;
			coef_s1 <= stencil_coef(job_q.kind, tap_q[2:0]);
			if (tap_q == '0)
				acc_q <= '0;
			else if (tap_q <= 4'(TAPS))
				acc_q <= acc_q + 64'(tap_prod);
			else
				wp_q <= rd_s1;
		end
		if (state_q == B_D1_WAIT && div_done)
			d_q <= sat48(acc_q[63], div_big, div_quo);
		if (state_q == B_F)
			f_q <= diff * kp1;
		if (state_q == B_D2_WAIT && div_done && !comp_q)
			res_re_q <= res;
		if (state_q == B_D2_WAIT && div_done && comp_q)
			res_im_q <= res;
		// Result register
		if (state_q == B_OUT && out_free) begin
			out_short_q <= job_q.short_run;
			out_fin_q   <= job_q.fin;
			if (job_q.short_run) begin
				out_re_q  <= '0;
				out_im_q  <= '0;
				out_idx_q <= '0;
			end else begin
				out_re_q  <= res_re_q;
				out_im_q  <= res_im_q;
				out_idx_q <= job_q.point[IDX_W-1:0];
			end
		end
	end

	assign derivs.valid        = out_valid_q;
	assign derivs.deriv_re     = out_re_q;
	assign derivs.deriv_im     = out_im_q;
	assign derivs.point_index  = out_idx_q;
	assign derivs.final_result = out_fin_q;
	assign derivs.too_short    = out_short_q;

endmodule

@@ design/radial_potential_derivative.sv @@
// Top level of the radial potential derivative block: configuration registers and wiring.
//
// Takes one complex potential sample with its radius per request, weights it by r^2 and emits
// the scaled log-grid derivative of each point (r^2 v)' as soon as the eight-sample window
// holds its stencil; a request flagged last_point flushes the run, and a run of fewer than
// eight points gives one too_short result. The front weights a sample with a 64x64 multiplier
// built from four 32x32 partial products (four products per sample); the back has a single
// radix-2 divider that runs four 48-bit divisions per result (two per real and imaginary
// part). The front takes a new sample while the back still works, but writes it into the
// window only once the back and its request queue are empty.
module radial_potential_derivative import rpd_pkg::*; #(
	parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rpd_sample_if.sink           samples,
	rpd_result_if.source         derivs,
	input  logic                 write_en,
	input  logic [REG_IDX_W-1:0] reg_index,
	input  logic [CFG_W-1:0]     write_data
);

	cfg_t    cfg_q;
	win_wr_t win_wr;
	job_t    push_job, head;
	logic    push, pop, queue_empty, queue_full, back_idle;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kappa <= KAPPA_RESET;
			cfg_q.light <= LIGHT_RESET;
			cfg_q.grid  <= GRID_RESET;
		end else if (write_en) begin
			unique case (reg_index)
				REG_KAPPA: cfg_q.kappa <= write_data[KAPPA_W-1:0];
				REG_LIGHT: cfg_q.light <= write_data[LIGHT_W-1:0];
				REG_GRID:  cfg_q.grid  <= write_data[GRID_W-1:0];
				default:   ;
			endcase
		end
	end

	rpd_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.back_idle (back_idle),
		.queue_full(queue_full),
		.win_wr    (win_wr),
		.push      (push),
		.push_job  (push_job)
	);

	rpd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.empty   (queue_empty),
		.full    (queue_full)
	);

	rpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.win_wr     (win_wr),
		.head       (head),
		.queue_empty(queue_empty),
		.pop        (pop),
		.back_idle  (back_idle),
		.derivs     (derivs)
	);

endmodule

@@ sim/rpd_checker.sv @@
// Checker of the radial potential derivative block: predicts results per request and compares.
`timescale 1ns / 1ps

module rpd_checker import rpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	rpd_sample_if                samples,
	rpd_result_if                derivs,
	input  logic                 write_en,
	input  logic [REG_IDX_W-1:0] reg_index,
	input  logic [CFG_W-1:0]     write_data,
	output int                   fails,
	output int                   pending
);

	localparam logic [127:0] QCAP     = 128'd1 << 62;
	localparam int           PT_LIMIT = DEFAULT_MAX_POINTS;

	typedef struct {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
		logic [IDX_W-1:0]         idx;
		logic                     fin;
		logic                     too_short;
	} deriv_exp_t;

	deriv_exp_t expected_derivs[$];

	// Model copy of the window and the registers
	logic signed [DATA_W-1:0]  wre [WIN_DEPTH];
	logic signed [DATA_W-1:0]  wim [WIN_DEPTH];
	logic [DATA_W-1:0]         rad [WIN_DEPTH];
	int                        seen;
	logic signed [KAPPA_W-1:0] kappa;
	logic [LIGHT_W-1:0]        light;
	logic [GRID_W-1:0]         grid;

	assign pending = expected_derivs.size();

	// Rounded quotient, ties away from zero, capped at 2^62
	function automatic logic [63:0] round_div(logic [127:0] num, logic [127:0] den);
		logic [127:0] q, r;
		if (den == 0)
			return (num != 0) ? QCAP[63:0] : 64'd0;
		q = num / den;
		r = num % den;
		if (q >= QCAP)
			return QCAP[63:0];
		if ({r, 1'b0} >= {1'b0, den})
			q = q + 1;
		return q[63:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] clamp48(logic neg, logic [63:0] mag);
		if (mag >= (64'd1 << 47))
			return neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		return neg ? -mag[DATA_W-1:0] : mag[DATA_W-1:0];
	endfunction

	// v * r * r, each product scaled by 2^-40 and rounded on the magnitude
	function automatic logic signed [DATA_W-1:0] weigh(logic [DATA_W-1:0] v,
			logic [DATA_W-1:0] r);
		logic        neg;
		logic [63:0] m, t;
		neg = v[DATA_W-1];
		m = neg ? ((64'd1 << 48) - 64'(v)) : 64'(v);
		t = round_div(128'(m) * 128'(r), 128'd1 << 40);
		return clamp48(neg, round_div(128'(t) * 128'(r), 128'd1 << 40));
	endfunction

	function automatic longint tap(logic im, int pos);
		return im ? longint'(wim[pos & (WIN_DEPTH-1)]) : longint'(wre[pos & (WIN_DEPTH-1)]);
	endfunction

	// Scaled derivative of one part at point p
	function automatic logic signed [DATA_W-1:0] scaled_deriv(logic im, int p, stencil_t kind);
		longint       s, d, f;
		longint       dv;
		logic [63:0]  m;
		logic [127:0] num, den;
		case (kind)
			ST_ONE_SIDED: begin
				s = -147 * tap(im, p) + 360 * tap(im, p+1) - 450 * tap(im, p+2)
					+ 400 * tap(im, p+3) - 225 * tap(im, p+4) + 72 * tap(im, p+5)
					- 10 * tap(im, p+6);
				dv = 60;
			end
			ST_CENTRAL: begin
				s = tap(im, p-2) - 8 * tap(im, p-1) + 8 * tap(im, p+1) - tap(im, p+2);
				dv = 12;
			end
			ST_NEXT_LAST: begin
				s = tap(im, p+1) - tap(im, p-1);
				dv = 2;
			end
			default: begin
				s = tap(im, p-2) - 4 * tap(im, p-1) + 3 * tap(im, p);
				dv = 2;
			end
		endcase
		m = (s < 0) ? -s : s;
		num = 128'(m) << 24;
		den = 128'(dv) * 128'(grid);
		d = longint'(clamp48(s < 0, round_div(num, den)));
		f = (d - 2 * tap(im, p)) * (longint'(kappa) + 1);
		m = (f < 0) ? -f : f;
		num = 128'(m) << 56;
		den = 128'(rad[p & (WIN_DEPTH-1)]) * 128'(light);
		return clamp48(f < 0, round_div(num, den));
	endfunction

	task automatic add_deriv(int p, stencil_t kind, logic fin);
		deriv_exp_t e;
		e.re = scaled_deriv(1'b0, p, kind);
		e.im = scaled_deriv(1'b1, p, kind);
		e.idx = p[IDX_W-1:0];
		e.fin = fin;
		e.too_short = 1'b0;
		expected_derivs.push_back(e);
	endtask

	// Window update and emission for one accepted sample
	task automatic predict_sample(logic [DATA_W-1:0] pr, logic [DATA_W-1:0] pi,
			logic [DATA_W-1:0] r, logic lp);
		int         k;
		logic       last;
		deriv_exp_t e;
		k = seen;
		last = lp || (k >= PT_LIMIT - 1);
		rad[k & (WIN_DEPTH-1)] = r;
		wre[k & (WIN_DEPTH-1)] = weigh(pr, r);
		wim[k & (WIN_DEPTH-1)] = weigh(pi, r);
		if (last && k < 7) begin
			e.re = '0;
			e.im = '0;
			e.idx = '0;
			e.fin = 1'b1;
			e.too_short = 1'b1;
			expected_derivs.push_back(e);
			seen = 0;
			return;
		end
		if (k == 6) begin
			add_deriv(0, ST_ONE_SIDED, 1'b0);
			add_deriv(2, ST_CENTRAL, 1'b0);
			add_deriv(3, ST_CENTRAL, 1'b0);
			add_deriv(4, ST_CENTRAL, 1'b0);
		end else if (k == 7) begin
			add_deriv(1, ST_ONE_SIDED, 1'b0);
			add_deriv(5, ST_CENTRAL, 1'b0);
		end else if (k >= 8) begin
			add_deriv(k - 2, ST_CENTRAL, 1'b0);
		end
		if (last) begin
			add_deriv(k - 1, ST_NEXT_LAST, 1'b0);
			add_deriv(k, ST_LAST, 1'b1);
			seen = 0;
		end else begin
			seen = k + 1;
		end
	endtask

	// Register writes, sample requests and result requests
	always @(posedge clk or negedge arst_n) begin
		deriv_exp_t e;
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				wre[i] = '0;
				wim[i] = '0;
				rad[i] = '0;
			end
			seen = 0;
			kappa = KAPPA_RESET;
			light = LIGHT_RESET;
			grid = GRID_RESET;
			fails = 0;
			expected_derivs.delete();
		end else begin
			if (derivs.valid && derivs.ready) begin
				if (expected_derivs.size() == 0) begin
					$error("unexpected result, point_index %0d", derivs.point_index);
					fails++;
				end else begin
					e = expected_derivs.pop_front();
					if (derivs.deriv_re !== e.re) begin
						$error("deriv_re expected %0d got %0d", e.re, derivs.deriv_re);
						fails++;
					end
					if (derivs.deriv_im !== e.im) begin
						$error("deriv_im expected %0d got %0d", e.im, derivs.deriv_im);
						fails++;
					end
					if (derivs.point_index !== e.idx) begin
						$error("point_index expected %0d got %0d", e.idx, derivs.point_index);
						fails++;
					end
					if (derivs.final_result !== e.fin) begin
						$error("final_result expected %0d got %0d", e.fin, derivs.final_result);
						fails++;
					end
					if (derivs.too_short !== e.too_short) begin
						$error("too_short expected %0d got %0d", e.too_short, derivs.too_short);
						fails++;
					end
				end
			end
			if (samples.valid && samples.ready)
				predict_sample(samples.pot_re, samples.pot_im, samples.radius,
					samples.last_point);
			if (write_en) begin
				case (reg_index)
					REG_KAPPA: kappa = write_data[KAPPA_W-1:0];
					REG_LIGHT: light = write_data[LIGHT_W-1:0];
					REG_GRID:  grid = write_data[GRID_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

@@ sim/tb_radial_potential_derivative.sv @@
// Testbench top of the radial potential derivative block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_radial_potential_derivative;
	import rpd_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int SETTLE      = 300;
	localparam int PHASE_ITEMS = 66;

	logic                 clk;
	logic                 arst_n;
	logic                 write_en;
	logic [REG_IDX_W-1:0] reg_index;
	logic [CFG_W-1:0]     write_data;
	int                   fails;
	int                   pending;
	int                   tx_idle;
	int                   rx_idle;
	int                   quiet;
	int                   sent;

	rpd_sample_if smp();
	rpd_result_if res();

	radial_potential_derivative uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (smp),
		.derivs    (res),
		.write_en  (write_en),
		.reg_index (reg_index),
		.write_data(write_data)
	);

	rpd_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (smp),
		.derivs    (res),
		.write_en  (write_en),
		.reg_index (reg_index),
		.write_data(write_data),
		.fails     (fails),
		.pending   (pending)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Receiver stalls
	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= rx_idle);
	end

	// Watchdog on cycles with no request moving
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [DATA_W-1:0] pick_pot();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(9))
			0: return {1'b0, {(DATA_W-1){1'b1}}};
			1: return {1'b1, {(DATA_W-1){1'b0}}};
			2, 3: return raw[DATA_W-1:0];
			default: return DATA_W'($signed(raw[29:0]));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_radius();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(9))
			0: return DATA_W'(1);
			1: return {DATA_W{1'b1}};
			2: return (raw[DATA_W-1:0] == 0) ? DATA_W'(1) : raw[DATA_W-1:0];
			default: return (DATA_W'(1) << 34) + DATA_W'(raw[41:0]);
		endcase
	endfunction

	// One sample request; leaves valid high after acceptance
	task automatic send(logic [DATA_W-1:0] pr, logic [DATA_W-1:0] pi,
			logic [DATA_W-1:0] r, logic lp);
		while ($urandom_range(99) < tx_idle) begin
			smp.valid <= 1'b0;
			@(negedge clk);
		end
		smp.valid <= 1'b1;
		smp.pot_re <= pr;
		smp.pot_im <= pi;
		smp.radius <= r;
		smp.last_point <= lp;
		do
			@(posedge clk);
		while (!smp.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_run(int len);
		for (int i = 0; i < len; i++)
			send(pick_pot(), pick_pot(), pick_radius(), i == len - 1);
	endtask

	// Wait until every result is in, then let the block run dry
	task automatic settle();
		smp.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_regs(int kap, logic [LIGHT_W-1:0] lt, logic [GRID_W-1:0] gs);
		write_en <= 1'b1;
		reg_index <= REG_KAPPA;
		write_data <= CFG_W'(kap);
		@(negedge clk);
		reg_index <= REG_LIGHT;
		write_data <= CFG_W'(lt);
		@(negedge clk);
		reg_index <= REG_GRID;
		write_data <= CFG_W'(gs);
		@(negedge clk);
		write_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_phase(int items);
		int start;
		start = sent;
		while (sent - start < items) begin
			if ($urandom_range(9) == 0)
				send_run($urandom_range(1, 7));
			else
				send_run($urandom_range(8, 16));
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		write_en = 1'b0;
		reg_index = REG_KAPPA;
		write_data = '0;
		smp.valid = 1'b0;
		smp.pot_re = '0;
		smp.pot_im = '0;
		smp.radius = '0;
		smp.last_point = 1'b0;
		res.ready = 1'b0;
		tx_idle = 0;
		rx_idle = 0;
		quiet = 0;
		sent = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes, short runs, minimum full run
		write_regs(3, LIGHT_RESET, GRID_RESET);
		send({1'b0, {(DATA_W-1){1'b1}}}, {1'b1, {(DATA_W-1){1'b0}}}, DATA_W'(1), 1'b0);
		send({1'b1, {(DATA_W-1){1'b0}}}, {1'b0, {(DATA_W-1){1'b1}}}, {DATA_W{1'b1}}, 1'b0);
		send('0, '1, DATA_W'(1) << 40, 1'b0);
		send('1, '0, DATA_W'(1) << 40, 1'b0);
		send(DATA_W'(1) << 24, -(DATA_W'(1) << 24), DATA_W'(1) << 41, 1'b0);
		send(DATA_W'(3) << 24, DATA_W'(5) << 20, DATA_W'(3) << 40, 1'b0);
		send(DATA_W'(7) << 22, DATA_W'(1), DATA_W'(1) << 42, 1'b1);
		send(DATA_W'(12345), DATA_W'(54321), DATA_W'(1) << 39, 1'b1);
		send_run(8);
		settle();
		// factor kappa + 1 of zero
		write_regs(-1, LIGHT_RESET, GRID_RESET);
		send_run(8);
		settle();

		tx_idle = 25;
		rx_idle = 58;
		write_regs(-20, 32'hFFFF_FFFF, 24'h00_0001);
		random_phase(PHASE_ITEMS);

		tx_idle = 58;
		rx_idle = 25;
		write_regs(20, 32'd1, 24'hFF_FFFF);
		random_phase(PHASE_ITEMS);

		tx_idle = 0;
		rx_idle = 0;
		write_regs($urandom_range(40) - 20, $urandom | 32'd1, 24'($urandom) | 24'd1);
		random_phase(PHASE_ITEMS);

		if (fails == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
design/rpd_pkg.sv
design/rpd_if.sv
design/rpd_mul.sv
design/rpd_div.sv
design/rpd_front.sv
design/rpd_queue.sv
design/rpd_back.sv
design/radial_potential_derivative.sv
sim/rpd_checker.sv
sim/tb_radial_potential_derivative.sv
